@@ design/fibonacci_matrix_power_assert.svh @@
`ifndef FIBONACCI_MATRIX_POWER_ASSERT_SVH
`define FIBONACCI_MATRIX_POWER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FMP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FMP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fmp_pkg.sv @@
package fmp_pkg;

    localparam int INDEX_BITS   = 31;
    localparam int VALUE_BITS   = 32;
    localparam int SLICE_BITS   = 32;
    localparam int BIT_CNT_BITS = $clog2(INDEX_BITS);

    typedef enum logic [1:0] {
        PROD_AA,
        PROD_BB,
        PROD_CROSS
    } prod_sel_t;

    typedef struct packed {
        logic      valid;
        prod_sel_t sel;
    } mul_tag_t;

endpackage

@@ design/fmp_mul.sv @@
module fmp_mul
    import fmp_pkg::*;
#(
    parameter int RESULT_BITS = 32,
    parameter int SLICES      = 1,
    parameter int SW          = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mul_tag_t               issue_tag,
    input  logic [RESULT_BITS-1:0] x,
    input  logic [RESULT_BITS-1:0] y,
    input  logic [SW-1:0]          x_slice,
    input  logic [SW-1:0]          y_slice,
    output mul_tag_t               land_tag,
    output logic [RESULT_BITS-1:0] prod
);

    localparam int W  = SLICES * SLICE_BITS;
    localparam int PW = W + 2 * SLICE_BITS;

    logic [W-1:0]              x_pad;
    logic [W-1:0]              y_pad;
    logic [SLICE_BITS-1:0]     x_part;
    logic [SLICE_BITS-1:0]     y_part;
    logic [2*SLICE_BITS-1:0]   partial;
    logic [SW:0]               pos;
    logic [PW-1:0]             placed;
    mul_tag_t                  tag_reg;
    logic [RESULT_BITS-1:0]    prod_reg;

    assign x_pad   = W'(x);
    assign y_pad   = W'(y);
    assign x_part  = x_pad[x_slice*SLICE_BITS +: SLICE_BITS];
    assign y_part  = y_pad[y_slice*SLICE_BITS +: SLICE_BITS];
    assign partial = x_part * y_part;
    assign pos     = {1'b0, x_slice} + {1'b0, y_slice};
    assign placed  = PW'(partial) << (pos * SLICE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            prod_reg <= '0;
        end
        else
        begin
            tag_reg  <= issue_tag;
            prod_reg <= placed[RESULT_BITS-1:0];
        end
    end

    assign land_tag = tag_reg;
    assign prod     = prod_reg;

endmodule

@@ design/fibonacci_matrix_power.sv @@
// Returns the Fibonacci number at the requested index, modulo 2^RESULT_BITS and shown in a
// 32-bit field. The power of [[1,1],[1,0]] is held as its two distinct entries and squared once
// for each of the 31 exponent bits on one shared 32x32 multiplier, three products per bit, with
// the odd-bit step done by addition. With S = ceil(RESULT_BITS/32) and P = S*(S+1)/2 partial
// products per multiplication, each exponent bit issues 3*P partial products, then closes in
// the finish state; a request is accepted in idle and its result held in done until taken. An
// index of zero goes from idle straight to done. One request is in work at a time.
`include "fibonacci_matrix_power_assert.svh"

module fibonacci_matrix_power
    import fmp_pkg::*;
#(
    parameter int RESULT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [INDEX_BITS-1:0]  index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_BITS-1:0]  fib_value
);

    localparam int SLICES = (RESULT_BITS + SLICE_BITS - 1) / SLICE_BITS;
    localparam int SW     = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int CW     = (RESULT_BITS > VALUE_BITS) ? RESULT_BITS : VALUE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [RESULT_BITS-1:0]   a_reg, a_next;
    logic [RESULT_BITS-1:0]   b_reg, b_next;
    logic [RESULT_BITS-1:0]   m_reg, m_next;
    logic [RESULT_BITS-1:0]   sum_reg, sum_next;
    logic [RESULT_BITS-1:0]   cross_reg, cross_next;
    logic [INDEX_BITS-1:0]    e_reg, e_next;
    logic [BIT_CNT_BITS-1:0]  bit_reg, bit_next;
    prod_sel_t                sel_reg, sel_next;
    logic [SW-1:0]            i_reg, i_next;
    logic [SW-1:0]            j_reg, j_next;

    mul_tag_t                 issue_tag;
    mul_tag_t                 land_tag;
    logic [RESULT_BITS-1:0]   x_op;
    logic [RESULT_BITS-1:0]   y_op;
    logic [RESULT_BITS-1:0]   prod;
    logic [RESULT_BITS-1:0]   cross_fin;
    logic [CW-1:0]            a_wide;

    fmp_mul #(
        .RESULT_BITS (RESULT_BITS),
        .SLICES      (SLICES),
        .SW          (SW)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .x         (x_op),
        .y         (y_op),
        .x_slice   (i_reg),
        .y_slice   (j_reg),
        .land_tag  (land_tag),
        .prod      (prod)
    );

    // The running power is [[a,b],[b,a-b]]; its square needs a*a, b*b and b*(2a-b).
    always_comb
    begin
        x_op = a_reg;
        y_op = a_reg;
        case (sel_reg)
            PROD_AA:
            begin
                x_op = a_reg;
                y_op = a_reg;
            end
            PROD_BB:
            begin
                x_op = b_reg;
                y_op = b_reg;
            end
            PROD_CROSS:
            begin
                x_op = b_reg;
                y_op = m_reg;
            end
            default:
            begin
                x_op = a_reg;
                y_op = a_reg;
            end
        endcase
    end

    assign cross_fin = cross_reg + prod;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        m_next          = (a_reg << 1) - b_reg;
        sum_next        = sum_reg;
        cross_next      = cross_reg;
        e_next          = e_reg;
        bit_next        = bit_reg;
        sel_next        = sel_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        issue_tag       = '0;
        issue_tag.sel   = sel_reg;

        if (land_tag.valid && state_reg == ST_RUN)
        begin
            if (land_tag.sel == PROD_CROSS)
            begin
                cross_next = cross_reg + prod;
            end
            else
            begin
                sum_next = sum_reg + prod;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = RESULT_BITS'(1);
                    b_next     = '0;
                    sum_next   = '0;
                    cross_next = '0;
                    e_next     = index - INDEX_BITS'(1);
                    bit_next   = BIT_CNT_BITS'(INDEX_BITS - 1);
                    sel_next   = PROD_AA;
                    i_next     = '0;
                    j_next     = '0;
                    if (index == '0)
                    begin
                        a_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                issue_tag.valid = 1'b1;
                if (i_reg == SW'(SLICES - 1))
                begin
                    i_next = '0;
                    j_next = '0;
                    unique case (sel_reg)
                        PROD_AA:    sel_next   = PROD_BB;
                        PROD_BB:    sel_next   = PROD_CROSS;
                        PROD_CROSS: state_next = ST_FINISH;
                        default:    state_next = ST_FINISH;
                    endcase
                end
                else if (j_reg == SW'(SLICES - 1) - i_reg)
                begin
                    i_next = SW'(i_reg + 1'b1);
                    j_next = '0;
                end
                else
                begin
                    j_next = SW'(j_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                if (e_reg[INDEX_BITS-1])
                begin
                    a_next = sum_reg + cross_fin;
                    b_next = sum_reg;
                end
                else
                begin
                    a_next = sum_reg;
                    b_next = cross_fin;
                end
                sum_next   = '0;
                cross_next = '0;
                sel_next   = PROD_AA;
                e_next     = e_reg << 1;
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - BIT_CNT_BITS'(1);
                    state_next = ST_RUN;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            m_reg     <= '0;
            sum_reg   <= '0;
            cross_reg <= '0;
            e_reg     <= '0;
            bit_reg   <= '0;
            sel_reg   <= PROD_AA;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            m_reg     <= m_next;
            sum_reg   <= sum_next;
            cross_reg <= cross_next;
            e_reg     <= e_next;
            bit_reg   <= bit_next;
            sel_reg   <= sel_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    assign a_wide    = CW'(a_reg);
    assign fib_value = a_wide[VALUE_BITS-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    `FMP_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready,
        "a result is shown while a new request is taken")
    `FMP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
        "the block is still ready after taking a request")
    `FMP_ASSERT_NOW(a_land_in_work, clk, rst_n, land_tag.valid,
        state_reg == ST_RUN || state_reg == ST_FINISH,
        "a product lands outside the working states")
    `FMP_ASSERT_NOW(a_finish_has_cross, clk, rst_n, state_reg == ST_FINISH,
        land_tag.valid && land_tag.sel == PROD_CROSS,
        "the step closes without its last cross product")

endmodule

@@ test/fib_value_checker.sv @@
`timescale 1ns / 100ps

module fib_value_checker
    import fmp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [INDEX_BITS-1:0]  index,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [VALUE_BITS-1:0]  fib_value,
    output int                     error_count,
    output int                     outstanding
);

    typedef struct {
        logic [INDEX_BITS-1:0] position;
        logic [VALUE_BITS-1:0] value;
    } fib_expect_t;

    fib_expect_t expected_values [$];

    function automatic logic [VALUE_BITS-1:0] fib_mod32(input logic [INDEX_BITS-1:0] n);
        logic [VALUE_BITS-1:0] pa, pb, pc, pd;
        logic [VALUE_BITS-1:0] sq_a, sq_b, sq_c, sq_d;
        logic [INDEX_BITS-1:0] power;
        if (n == '0)
            return '0;
        power = n - 1'b1;
        pa = 1;
        pb = 0;
        pc = 0;
        pd = 1;
        for (int i = INDEX_BITS - 1; i >= 0; i--)
        begin
            sq_a = pa * pa + pb * pc;
            sq_b = pa * pb + pb * pd;
            sq_c = pc * pa + pd * pc;
            sq_d = pc * pb + pd * pd;
            if (power[i])
            begin
                pa = sq_a + sq_b;
                pb = sq_a;
                pc = sq_c + sq_d;
                pd = sq_c;
            end
            else
            begin
                pa = sq_a;
                pb = sq_b;
                pc = sq_c;
                pd = sq_d;
            end
        end
        return pa;
    endfunction

    initial
    begin
        error_count = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        fib_expect_t oldest;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("fib_value %0d returned with no request outstanding", fib_value);
                    error_count++;
                end
                else
                begin
                    oldest = expected_values.pop_front();
                    if (fib_value !== oldest.value)
                    begin
                        $error("fib_value mismatch for index %0d: expected %0d, actual %0d",
                               oldest.position, oldest.value, fib_value);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_values.push_back('{position: index, value: fib_mod32(index)});
            outstanding = expected_values.size();
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
    import fmp_pkg::*;
();

    localparam int RANDOM_REQUESTS = 1130;
    localparam int CALM_TAIL       = 150;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [INDEX_BITS-1:0] index;
    logic                  out_valid;
    logic                  out_ready;
    logic [VALUE_BITS-1:0] fib_value;
    int                    error_count;
    int                    outstanding;
    int                    stall_pct;
    int                    cycle_count;

    fibonacci_matrix_power DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fib_value (fib_value)
    );

    fib_value_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fib_value   (fib_value),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        index = '0;
        out_ready = 1'b0;
        stall_pct = 0;
        cycle_count = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(1, 100) <= stall_pct)
            begin
                stall = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_request(input logic [INDEX_BITS-1:0] n);
        if ($urandom_range(1, 100) <= stall_pct)
            pause_sender($urandom_range(1, 18));
        @(negedge clk);
        in_valid <= 1'b1;
        index <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [INDEX_BITS-1:0] random_index();
        logic [31:0] raw;
        logic [INDEX_BITS-1:0] pick;
        raw = $urandom();
        case ($urandom_range(0, 5))
            0: pick = INDEX_BITS'($urandom_range(0, 64));
            1: pick = INDEX_BITS'($urandom_range(0, 5000));
            2: pick = {{(INDEX_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, INDEX_BITS - 1);
            3: pick = ~({{(INDEX_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, INDEX_BITS - 1));
            4: pick = {INDEX_BITS{1'b1}} - INDEX_BITS'($urandom_range(0, 300));
            default: pick = raw[INDEX_BITS-1:0];
        endcase
        return pick;
    endfunction

    initial
    begin
        logic [INDEX_BITS-1:0] corner_indices [22];
        corner_indices = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd12, 31'd46,
                           31'd47, 31'd48, 31'd49, 31'd93, 31'd94, 31'd1000, 31'h0001_0000,
                           31'h3FFF_FFFF, 31'h4000_0000, 31'h4000_0001, 31'h2AAA_AAAA,
                           31'h5555_5555, 31'h7FFF_FFFE, 31'h7FFF_FFFF};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        stall_pct = 30;
        foreach (corner_indices[i])
            send_request(corner_indices[i]);

        // Hold off new requests until every result of the directed part is back.
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);

        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k >= RANDOM_REQUESTS - CALM_TAIL)
                stall_pct = 0;
            else if (k % 100 == 0)
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 60;
                endcase
            send_request(random_index());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
